@@ hw/rtl/mm_pkg.sv @@
package mm_pkg;

   localparam int DIM_W   = 4;
   localparam int IDX_W   = 3;
   localparam int VAL_W   = 16;
   localparam int PROD_W  = 32;
   localparam int ACC_W   = 40;
   localparam int CSR_A_W = 2;

   typedef enum logic [1:0] {
      CMD_LOAD_A  = 2'd0,
      CMD_LOAD_B  = 2'd1,
      CMD_COMPUTE = 2'd2
   } cmd_type;

   typedef enum logic [CSR_A_W-1:0] {
      REG_ROWS_A    = 2'd0,
      REG_INNER_DIM = 2'd1,
      REG_COLS_B    = 2'd2
   } reg_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MAC,
      ST_DRAIN1,
      ST_DRAIN2,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic             wr_a;
      logic             wr_b;
      logic             mac_issue;
      logic             clear_acc;
      logic             load_out;
      logic [DIM_W-1:0] idx_i;
      logic [DIM_W-1:0] idx_j;
      logic [DIM_W-1:0] idx_t;
      logic             last;
   } ctl_type;

   typedef struct packed {
      logic out_full;
   } stat_type;

endpackage

@@ hw/rtl/mm_ctrl.sv @@
module mm_ctrl #(
   parameter int MAX_DIM = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [1:0]                    req_cmd,
   input  logic [mm_pkg::IDX_W-1:0]      req_row,
   input  logic [mm_pkg::IDX_W-1:0]      req_col,
   input  logic                          csr_wr_en,
   input  logic [mm_pkg::CSR_A_W-1:0]    csr_index,
   input  logic [mm_pkg::DIM_W-1:0]      csr_wdata,
   input  mm_pkg::stat_type              stat,
   output mm_pkg::ctl_type               ctl
);

   localparam int DW = mm_pkg::DIM_W;
   localparam logic [DW:0] MAX_DIM_EXT = (DW+1)'(MAX_DIM);

   mm_pkg::state_type state_ff, state_in;
   logic [DW-1:0] rows_a_ff, inner_dim_ff, cols_b_ff;
   logic [DW-1:0] i_ff, i_in, j_ff, j_in, t_ff, t_in;
   logic [DW-1:0] dim_m, dim_k, dim_n;
   logic          accept, last_elem;

   // sizes above the store dimension saturate
   assign dim_m = ({1'b0, rows_a_ff} > MAX_DIM_EXT) ? MAX_DIM_EXT[DW-1:0] : rows_a_ff;
   assign dim_k = ({1'b0, inner_dim_ff} > MAX_DIM_EXT) ? MAX_DIM_EXT[DW-1:0] : inner_dim_ff;
   assign dim_n = ({1'b0, cols_b_ff} > MAX_DIM_EXT) ? MAX_DIM_EXT[DW-1:0] : cols_b_ff;

   assign accept    = req_valid && req_ready;
   assign last_elem = (i_ff == dim_m - DW'(1)) && (j_ff == dim_n - DW'(1));

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_a_ff    <= DW'(1);
         inner_dim_ff <= DW'(1);
         cols_b_ff    <= DW'(1);
      end else if (csr_wr_en) begin
         unique case (csr_index)
            mm_pkg::REG_ROWS_A:    rows_a_ff    <= csr_wdata;
            mm_pkg::REG_INNER_DIM: inner_dim_ff <= csr_wdata;
            mm_pkg::REG_COLS_B:    cols_b_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mm_pkg::ST_IDLE;
         i_ff     <= '0;
         j_ff     <= '0;
         t_ff     <= '0;
      end else begin
         state_ff <= state_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
         t_ff     <= t_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      t_in          = t_ff;
      req_ready     = 1'b0;
      ctl           = '0;
      ctl.idx_i     = i_ff;
      ctl.idx_j     = j_ff;
      ctl.idx_t     = t_ff;
      ctl.last      = last_elem;
      unique case (state_ff)
         mm_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (accept) begin
               unique case (req_cmd)
                  mm_pkg::CMD_LOAD_A:
                     ctl.wr_a = ({1'b0, req_row} < dim_m) && ({1'b0, req_col} < dim_k);
                  mm_pkg::CMD_LOAD_B:
                     ctl.wr_b = ({1'b0, req_row} < dim_k) && ({1'b0, req_col} < dim_n);
                  mm_pkg::CMD_COMPUTE: begin
                     if (dim_m != '0 && dim_n != '0) begin
                        i_in          = '0;
                        j_in          = '0;
                        t_in          = '0;
                        ctl.clear_acc = 1'b1;
                        state_in      = (dim_k == '0) ? mm_pkg::ST_EMIT : mm_pkg::ST_MAC;
                     end
                  end
                  default: ;
               endcase
            end
         end
         mm_pkg::ST_MAC: begin
            ctl.mac_issue = 1'b1;
            if (t_ff == dim_k - DW'(1)) begin
               t_in     = '0;
               state_in = mm_pkg::ST_DRAIN1;
            end else begin
               t_in = t_ff + DW'(1);
            end
         end
         // read and multiply stages still in flight
         mm_pkg::ST_DRAIN1: state_in = mm_pkg::ST_DRAIN2;
         mm_pkg::ST_DRAIN2: state_in = mm_pkg::ST_EMIT;
         mm_pkg::ST_EMIT: begin
            if (!stat.out_full) begin
               ctl.load_out  = 1'b1;
               ctl.clear_acc = 1'b1;
               if (last_elem) begin
                  state_in = mm_pkg::ST_IDLE;
               end else begin
                  if (j_ff == dim_n - DW'(1)) begin
                     j_in = '0;
                     i_in = i_ff + DW'(1);
                  end else begin
                     j_in = j_ff + DW'(1);
                  end
                  state_in = (dim_k == '0) ? mm_pkg::ST_EMIT : mm_pkg::ST_MAC;
               end
            end
         end
         default: state_in = mm_pkg::ST_IDLE;
      endcase
   end

endmodule

@@ hw/rtl/mm_datapath.sv @@
module mm_datapath #(
   parameter int MAX_DIM = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  mm_pkg::ctl_type                   ctl,
   output mm_pkg::stat_type                  stat,
   input  logic [mm_pkg::IDX_W-1:0]          req_row,
   input  logic [mm_pkg::IDX_W-1:0]          req_col,
   input  logic signed [mm_pkg::VAL_W-1:0]   req_value,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [mm_pkg::IDX_W-1:0]          rsp_res_row,
   output logic [mm_pkg::IDX_W-1:0]          rsp_res_col,
   output logic signed [mm_pkg::ACC_W-1:0]   rsp_res_value,
   output logic                              rsp_last
);

   localparam int DEPTH = MAX_DIM * MAX_DIM;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int VW    = mm_pkg::VAL_W;
   localparam int PW    = mm_pkg::PROD_W;
   localparam int CW    = mm_pkg::ACC_W;
   localparam int IW    = mm_pkg::IDX_W;

   logic [VW-1:0] a_mem [DEPTH];
   logic [VW-1:0] b_mem [DEPTH];

   logic [AW-1:0]        wr_addr, a_addr, b_addr;
   logic signed [VW-1:0] a_rd_ff, b_rd_ff;
   logic                 rd_vld_ff, prod_vld_ff, rsp_valid_ff;
   logic signed [PW-1:0] prod_ff;
   logic signed [CW-1:0] acc_ff, acc_in;
   logic [IW-1:0]        res_row_ff, res_col_ff;
   logic signed [CW-1:0] res_value_ff;
   logic                 res_last_ff;

   assign wr_addr = AW'(req_row * MAX_DIM + req_col);
   assign a_addr  = AW'(ctl.idx_i * MAX_DIM + ctl.idx_t);
   assign b_addr  = AW'(ctl.idx_t * MAX_DIM + ctl.idx_j);

   always_ff @(posedge clock) begin
      if (ctl.wr_a) a_mem[wr_addr] <= req_value;
      if (ctl.wr_b) b_mem[wr_addr] <= req_value;
      a_rd_ff <= a_mem[a_addr];
      b_rd_ff <= b_mem[b_addr];
   end

   always_ff @(posedge clock) begin
      prod_ff <= a_rd_ff * b_rd_ff;
      acc_ff  <= acc_in;
   end

   always_comb begin
      acc_in = acc_ff;
      if (ctl.clear_acc) acc_in = '0;
      else if (prod_vld_ff) acc_in = acc_ff + CW'(prod_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff    <= 1'b0;
         prod_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rd_vld_ff   <= ctl.mac_issue;
         prod_vld_ff <= rd_vld_ff;
         if (ctl.load_out) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load_out) begin
         res_row_ff   <= ctl.idx_i[IW-1:0];
         res_col_ff   <= ctl.idx_j[IW-1:0];
         res_value_ff <= acc_ff;
         res_last_ff  <= ctl.last;
      end
   end

   assign stat.out_full = rsp_valid_ff && !rsp_ready;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_res_row   = res_row_ff;
   assign rsp_res_col   = res_col_ff;
   assign rsp_res_value = res_value_ff;
   assign rsp_last      = res_last_ff;

endmodule

@@ hw/rtl/matrix_multiply_top.sv @@
// Fixed-point matrix product C = A x B. Load items (cmd 0 for A, cmd 1 for B) write one
// signed Q8.8 element at row/col into on-chip stores; loads outside the configured size
// are dropped. A compute item (cmd 2) streams C in row-major order as signed Q24.16 sums,
// with last set on the final element. Each element is produced by the single shared
// multiply-accumulate fed from one read port per store, plus a read, a multiply and an
// output load stage; a compute stalls while the result side stalls. Loads and new
// commands are taken only between computes. Sizes are written through the csr port (index
// 0 rows_a, 1 inner_dim, 2 cols_b) and saturate at MAX_DIM; the user must write them only
// while idle, which the block itself does not enforce. Store contents are undefined until
// loaded.
module matrix_multiply_top #(
   parameter int MAX_DIM = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [1:0]                        req_cmd,
   input  logic [mm_pkg::IDX_W-1:0]          req_row,
   input  logic [mm_pkg::IDX_W-1:0]          req_col,
   input  logic signed [mm_pkg::VAL_W-1:0]   req_value,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [mm_pkg::IDX_W-1:0]          rsp_res_row,
   output logic [mm_pkg::IDX_W-1:0]          rsp_res_col,
   output logic signed [mm_pkg::ACC_W-1:0]   rsp_res_value,
   output logic                              rsp_last,
   input  logic                              csr_wr_en,
   input  logic [mm_pkg::CSR_A_W-1:0]        csr_index,
   input  logic [mm_pkg::DIM_W-1:0]          csr_wdata
);

   mm_pkg::ctl_type  ctl;
   mm_pkg::stat_type stat;

   mm_ctrl #(.MAX_DIM(MAX_DIM)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_cmd   (req_cmd),
      .req_row   (req_row),
      .req_col   (req_col),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .stat      (stat),
      .ctl       (ctl)
   );

   mm_datapath #(.MAX_DIM(MAX_DIM)) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .ctl           (ctl),
      .stat          (stat),
      .req_row       (req_row),
      .req_col       (req_col),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_res_row   (rsp_res_row),
      .rsp_res_col   (rsp_res_col),
      .rsp_res_value (rsp_res_value),
      .rsp_last      (rsp_last)
   );

endmodule

@@ hw/rtl/mm_checker.sv @@
module mm_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic [1:0]                        req_cmd,
   input logic [mm_pkg::IDX_W-1:0]          req_row,
   input logic [mm_pkg::IDX_W-1:0]          req_col,
   input logic signed [mm_pkg::VAL_W-1:0]   req_value,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [mm_pkg::IDX_W-1:0]          rsp_res_row,
   input logic [mm_pkg::IDX_W-1:0]          rsp_res_col,
   input logic signed [mm_pkg::ACC_W-1:0]   rsp_res_value,
   input logic                              rsp_last
);

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_res_row) && $stable(rsp_res_col)
         && $stable(rsp_res_value) && $stable(rsp_last))
      else $error("stalled result changed");

   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // no new item while a product is still streaming
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> !req_ready)
      else $error("item taken during a compute");

   // an offered item waits unchanged until taken
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_cmd) && $stable(req_row)
         && $stable(req_col) && $stable(req_value))
      else $error("offered item changed before accept");

endmodule

bind matrix_multiply_top mm_checker u_mm_checker (.*);
